FILE: hdl/tpq_pkg.sv
`default_nettype none
package tpq_pkg;

    localparam int NODE_W = 14;
    localparam int WGT_W  = 24;
    localparam int STEP_W = 15;
    localparam int DIST_W = 38;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_DIST  = 2'd1,
        REQ_KTH   = 2'd2,
        REQ_CLEAR = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_LOADED = 2'd1,
        ST_K_RANGE    = 2'd2,
        ST_NO_MEET    = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_CLEAR,
        OP_STATUS,
        OP_ROOT_WR,
        OP_LOAD_BASE,
        OP_LOAD_RD,
        OP_LOAD_WR,
        OP_MARK,
        OP_MEET_INIT,
        OP_CLB_STEP,
        OP_CLB_TAKE,
        OP_LCA_INIT,
        OP_LCA_RD,
        OP_LCA_CMP,
        OP_LCA_TOP,
        OP_LCA_FIN,
        OP_DIST_U,
        OP_DIST_V,
        OP_KTH,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_ROOT_WR,
        S_LOAD_BASE,
        S_LOAD_RD,
        S_LOAD_WR,
        S_MARK,
        S_MEET_INIT,
        S_CLB_STEP,
        S_CLB_TAKE,
        S_CLB_END,
        S_LCA_RD,
        S_LCA_CMP,
        S_LCA_TOP,
        S_LCA_FIN,
        S_PATH,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        PH_MEET,
        PH_DIST_U,
        PH_DIST_V,
        PH_KTH
    } phase_t;

    typedef struct packed {
        dp_op_t  op;
        status_t st;
    } dp_cmd_t;

    typedef struct packed {
        req_type_t typ;
        logic      load_n_bad;
        logic      is_root;
        logic      load_p_fail;
        logic      query_fail;
        logic      len_bit;
        logic      lvl_last;
        logic      lvl_zero;
        logic      a_eq_b;
        logic      x_ne_y;
        logic      k_bad;
        logic      clr_last;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: hdl/tpq_req_if.sv
`default_nettype none
interface tpq_req_if;
    import tpq_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [NODE_W-1:0]   first_node;
    logic [NODE_W-1:0]   second_node;
    logic [WGT_W-1:0]    edge_weight;
    logic [STEP_W-1:0]   step_index;

    modport source (
        output valid, req_type, first_node, second_node, edge_weight, step_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, first_node, second_node, edge_weight, step_index,
        output ready
    );
endinterface
`default_nettype wire

FILE: hdl/tpq_rsp_if.sv
`default_nettype none
interface tpq_rsp_if;
    import tpq_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [DIST_W-1:0]   path_distance;
    logic [NODE_W-1:0]   found_node;

    modport source (
        output valid, status, path_distance, found_node,
        input  ready
    );
    modport sink (
        input  valid, status, path_distance, found_node,
        output ready
    );
endinterface
`default_nettype wire

FILE: hdl/tree_path_query_engine.sv
// Tree path query engine: lowest common ancestor and path queries by binary lifting.
// Channel req carries one request (load node, distance query, kth query, clear);
// channel rsp returns exactly one response per request, in order, with status,
// path_distance and found_node. Both use valid/ready; a request is taken when
// valid and ready are high at a rising edge.
// One request is worked at a time by a sequencer over jump tables
// with registered reads, so cost follows the table walks:
//   load: one read and one write per level; root: one write per level;
//   load or query naming an unloaded node: a not-loaded status only;
//   distance: depth climb, meeting search one level at a time, then two
//   summing climbs over the set bits of the two path lengths;
//   kth: depth climb and meeting search, then one climb; clear: a sweep
//   over every loaded mark.
// After reset a clearing pass runs over all MAX_NODES loaded marks,
// during which req.ready stays low.
// Responses sit in an output register; a new request is taken while one waits,
// and it finishes only once rsp.ready frees the register, so stalls never drop.
`default_nettype none
module tree_path_query_engine #(
    parameter int MAX_NODES = 16384,
    parameter int LEVELS    = 15
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tpq_req_if.sink   req,
    tpq_rsp_if.source rsp
);
    import tpq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     req_ready;
    logic     rsp_valid;

    tpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tpq_dpath #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req.req_type),
        .first_node    (req.first_node),
        .second_node   (req.second_node),
        .edge_weight   (req.edge_weight),
        .step_index    (req.step_index),
        .status        (rsp.status),
        .path_distance (rsp.path_distance),
        .found_node    (rsp.found_node)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
endmodule
`default_nettype wire

FILE: hdl/tpq_dpath.sv
`default_nettype none
module tpq_dpath #(
    parameter int MAX_NODES = 16384,
    parameter int LEVELS    = 15
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tpq_pkg::dp_cmd_t             cmd,
    output tpq_pkg::dp_stat_t                 stat,
    input  wire logic [1:0]                   req_type,
    input  wire logic [tpq_pkg::NODE_W-1:0]   first_node,
    input  wire logic [tpq_pkg::NODE_W-1:0]   second_node,
    input  wire logic [tpq_pkg::WGT_W-1:0]    edge_weight,
    input  wire logic [tpq_pkg::STEP_W-1:0]   step_index,
    output logic [1:0]                        status,
    output logic [tpq_pkg::DIST_W-1:0]        path_distance,
    output logic [tpq_pkg::NODE_W-1:0]        found_node
);
    import tpq_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = $clog2(LEVELS);
    localparam int CW = LEVELS + 1;
    localparam int JW = ((NW > LEVELS) ? NW : LEVELS) + 1;

    // tables
    logic [NODE_W-1:0] anc_mem   [LEVELS][MAX_NODES];
    logic [DIST_W-1:0] dist_mem  [LEVELS][MAX_NODES];
    logic [NW-1:0]     depth_mem [MAX_NODES];
    logic              mark_mem  [MAX_NODES];

    // request and working registers
    req_type_t         typ_reg;
    logic [NODE_W-1:0] u_reg, v_reg;
    logic [WGT_W-1:0]  w_reg;
    logic [STEP_W-1:0] k_reg;
    status_t           st_reg, st_next;
    logic [NODE_W-1:0] a_reg, a_next, b_reg, b_next, mid_reg, mid_next;
    logic [DIST_W-1:0] dsum_reg, dsum_next, s_reg, s_next;
    logic [LEVELS-1:0] len_reg, len_next;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic              swap_reg, swap_next;
    logic [NW-1:0]     diff_reg, diff_next;
    logic [CW-1:0]     c_reg, c_next;
    logic [NW-1:0]     clr_reg, clr_next;
    logic [1:0]        out_st_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic [NODE_W-1:0] out_node_reg;

    // read data
    logic [NODE_W-1:0] anc_rd0, anc_rd1;
    logic [DIST_W-1:0] dist_rd;
    logic [NW-1:0]     dep_rd0, dep_rd1;
    logic              mark_rd0, mark_rd1;

    // read addresses
    logic [LW-1:0]     rl0, rl1;
    logic [NODE_W-1:0] rn0;

    logic              lvl_last, lvl_zero;
    logic [LW-1:0]     lvl_inc;
    logic              rng_u, rng_v;
    logic [NW-1:0]     dep_new;
    logic [JW-1:0]     du, dv;
    logic [31:0]       kk, tot;
    logic              k_bad, kk_le_du;
    logic [DIST_W-1:0] sum_rd;

    assign lvl_last = (32'(lvl_reg) == LEVELS - 1);
    assign lvl_zero = (lvl_reg == '0);
    assign lvl_inc  = lvl_last ? lvl_reg : lvl_reg + 1'b1;
    assign rng_u    = (32'(u_reg) < MAX_NODES);
    assign rng_v    = (32'(v_reg) < MAX_NODES);
    assign dep_new  = (32'(dep_rd1) >= MAX_NODES - 1) ? NW'(MAX_NODES - 1)
                                                      : dep_rd1 + 1'b1;
    assign sum_rd   = (cmd.op == OP_LOAD_WR) ? dsum_reg + dist_rd : s_reg + dist_rd;

    // path lengths from u and v to the meeting node
    assign du       = JW'(c_reg) + (swap_reg ? JW'(0) : JW'(diff_reg));
    assign dv       = JW'(c_reg) + (swap_reg ? JW'(diff_reg) : JW'(0));
    assign kk       = 32'(k_reg) - 32'd1;
    assign tot      = 32'(du) + 32'(dv);
    assign k_bad    = (k_reg == '0) || (kk > tot);
    assign kk_le_du = (kk <= 32'(du));

    // read address selection
    always_comb
    begin
        rl0 = lvl_reg;
        rl1 = lvl_reg;
        rn0 = a_reg;
        case (cmd.op)
            OP_LOAD_RD:
            begin
                rl0 = lvl_reg - 1'b1;
                rn0 = mid_reg;
            end
            OP_LCA_TOP:
            begin
                rl0 = '0;
                rl1 = '0;
            end
            default:
            begin
                rl0 = lvl_reg;
            end
        endcase
    end

    // jump tables
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ROOT_WR)
        begin
            anc_mem[lvl_reg][NW'(u_reg)]  <= u_reg;
            dist_mem[lvl_reg][NW'(u_reg)] <= '0;
        end
        else if (cmd.op == OP_LOAD_BASE)
        begin
            anc_mem[0][NW'(u_reg)]  <= v_reg;
            dist_mem[0][NW'(u_reg)] <= DIST_W'(w_reg);
        end
        else if (cmd.op == OP_LOAD_WR)
        begin
            anc_mem[lvl_reg][NW'(u_reg)]  <= anc_rd0;
            dist_mem[lvl_reg][NW'(u_reg)] <= sum_rd;
        end
        anc_rd0 <= anc_mem[rl0][NW'(rn0)];
        anc_rd1 <= anc_mem[rl1][NW'(b_reg)];
        dist_rd <= dist_mem[rl0][NW'(rn0)];
    end

    // depth table
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ROOT_WR)
        begin
            depth_mem[NW'(u_reg)] <= '0;
        end
        else if (cmd.op == OP_LOAD_BASE)
        begin
            depth_mem[NW'(u_reg)] <= dep_new;
        end
        dep_rd0 <= depth_mem[NW'(u_reg)];
        dep_rd1 <= depth_mem[NW'(v_reg)];
    end

    // loaded marks
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CLEAR)
        begin
            mark_mem[clr_reg] <= 1'b0;
        end
        else if (cmd.op == OP_MARK)
        begin
            mark_mem[NW'(u_reg)] <= 1'b1;
        end
        mark_rd0 <= mark_mem[NW'(u_reg)];
        mark_rd1 <= mark_mem[NW'(v_reg)];
    end

    // working register updates
    always_comb
    begin
        st_next   = st_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        mid_next  = mid_reg;
        dsum_next = dsum_reg;
        s_next    = s_reg;
        len_next  = len_reg;
        lvl_next  = lvl_reg;
        swap_next = swap_reg;
        diff_next = diff_reg;
        c_next    = c_reg;
        clr_next  = clr_reg;
        case (cmd.op)
            OP_CAPTURE:
            begin
                st_next  = ST_OK;
                lvl_next = '0;
            end
            OP_CLEAR:
            begin
                clr_next = (32'(clr_reg) == MAX_NODES - 1) ? '0 : clr_reg + 1'b1;
            end
            OP_STATUS:
            begin
                st_next = cmd.st;
            end
            OP_ROOT_WR:
            begin
                lvl_next = lvl_inc;
            end
            OP_LOAD_BASE:
            begin
                mid_next  = v_reg;
                dsum_next = DIST_W'(w_reg);
                lvl_next  = LW'(1);
            end
            OP_LOAD_WR:
            begin
                mid_next  = anc_rd0;
                dsum_next = sum_rd;
                lvl_next  = lvl_inc;
            end
            OP_MEET_INIT:
            begin
                swap_next = (dep_rd0 < dep_rd1);
                if (dep_rd0 < dep_rd1)
                begin
                    a_next    = v_reg;
                    b_next    = u_reg;
                    diff_next = dep_rd1 - dep_rd0;
                    len_next  = LEVELS'(dep_rd1 - dep_rd0);
                end
                else
                begin
                    a_next    = u_reg;
                    b_next    = v_reg;
                    diff_next = dep_rd0 - dep_rd1;
                    len_next  = LEVELS'(dep_rd0 - dep_rd1);
                end
                c_next   = '0;
                s_next   = '0;
                lvl_next = '0;
            end
            OP_CLB_STEP:
            begin
                if (!len_reg[lvl_reg])
                begin
                    lvl_next = lvl_inc;
                end
            end
            OP_CLB_TAKE:
            begin
                a_next   = anc_rd0;
                s_next   = sum_rd;
                lvl_next = lvl_inc;
            end
            OP_LCA_INIT:
            begin
                lvl_next = LW'(LEVELS - 1);
            end
            OP_LCA_CMP:
            begin
                if (anc_rd0 != anc_rd1)
                begin
                    a_next = anc_rd0;
                    b_next = anc_rd1;
                    c_next = c_reg + (CW'(1) << lvl_reg);
                end
                lvl_next = lvl_zero ? lvl_reg : lvl_reg - 1'b1;
            end
            OP_LCA_FIN:
            begin
                c_next = c_reg + CW'(1);
            end
            OP_DIST_U:
            begin
                s_next   = '0;
                a_next   = u_reg;
                len_next = LEVELS'(du);
                lvl_next = '0;
            end
            OP_DIST_V:
            begin
                a_next   = v_reg;
                len_next = LEVELS'(dv);
                lvl_next = '0;
            end
            OP_KTH:
            begin
                a_next   = kk_le_du ? u_reg : v_reg;
                len_next = kk_le_du ? LEVELS'(kk) : LEVELS'(tot - kk);
                lvl_next = '0;
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
    end

    // sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            lvl_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
            lvl_reg <= lvl_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CAPTURE)
        begin
            typ_reg <= req_type_t'(req_type);
            u_reg   <= first_node;
            v_reg   <= second_node;
            w_reg   <= edge_weight;
            k_reg   <= step_index;
        end
        if (cmd.op == OP_EMIT)
        begin
            out_st_reg   <= st_reg;
            out_dist_reg <= (st_reg == ST_OK && typ_reg == REQ_DIST) ? s_reg : '0;
            out_node_reg <= (st_reg == ST_OK && typ_reg == REQ_KTH) ? a_reg : '0;
        end
        st_reg   <= st_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        mid_reg  <= mid_next;
        dsum_reg <= dsum_next;
        s_reg    <= s_next;
        len_reg  <= len_next;
        swap_reg <= swap_next;
        diff_reg <= diff_next;
        c_reg    <= c_next;
    end

    assign status        = out_st_reg;
    assign path_distance = out_dist_reg;
    assign found_node    = out_node_reg;

    // status to the controller
    always_comb
    begin
        stat.typ         = typ_reg;
        stat.load_n_bad  = !rng_u;
        stat.is_root     = (u_reg == v_reg);
        stat.load_p_fail = !rng_v || !mark_rd1;
        stat.query_fail  = !rng_u || !rng_v || !mark_rd0 || !mark_rd1;
        stat.len_bit     = len_reg[lvl_reg];
        stat.lvl_last    = lvl_last;
        stat.lvl_zero    = lvl_zero;
        stat.a_eq_b      = (a_reg == b_reg);
        stat.x_ne_y      = (anc_rd0 != anc_rd1);
        stat.k_bad       = k_bad;
        stat.clr_last    = (32'(clr_reg) == MAX_NODES - 1);
    end

    // level counter never leaves the table
    assert property (@(posedge clk) disable iff (!rst_n) 32'(lvl_reg) < LEVELS)
        else $error("level counter out of range");
    // a take step only follows a set bit of the jump length
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_CLB_STEP && len_reg[lvl_reg] && !lvl_last
        |=> lvl_reg == $past(lvl_reg))
        else $error("climb skipped a set bit");
    // clear sweep address advances by one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_CLEAR && 32'(clr_reg) < MAX_NODES - 1
        |=> clr_reg == $past(clr_reg) + 1'b1)
        else $error("clear sweep skipped an entry");
endmodule
`default_nettype wire

FILE: hdl/tpq_ctrl.sv
`default_nettype none
module tpq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    input  wire tpq_pkg::dp_stat_t  stat,
    output tpq_pkg::dp_cmd_t        cmd
);
    import tpq_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   clr_req_reg, clr_req_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    // next state
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        clr_req_next = clr_req_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = clr_req_reg ? S_FIN : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                clr_req_next = (stat.typ == REQ_CLEAR);
                state_next   = (stat.typ == REQ_CLEAR) ? S_CLEAR : S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.typ == REQ_LOAD)
                begin
                    if (stat.load_n_bad)
                    begin
                        state_next = S_FIN;
                    end
                    else if (stat.is_root)
                    begin
                        state_next = S_ROOT_WR;
                    end
                    else if (stat.load_p_fail)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_LOAD_BASE;
                    end
                end
                else
                begin
                    state_next = stat.query_fail ? S_FIN : S_MEET_INIT;
                end
            end
            S_ROOT_WR:
            begin
                state_next = stat.lvl_last ? S_MARK : S_ROOT_WR;
            end
            S_LOAD_BASE:
            begin
                state_next = S_LOAD_RD;
            end
            S_LOAD_RD:
            begin
                state_next = S_LOAD_WR;
            end
            S_LOAD_WR:
            begin
                state_next = stat.lvl_last ? S_MARK : S_LOAD_RD;
            end
            S_MARK:
            begin
                state_next = S_FIN;
            end
            S_MEET_INIT:
            begin
                phase_next = PH_MEET;
                state_next = S_CLB_STEP;
            end
            S_CLB_STEP:
            begin
                if (stat.len_bit)
                begin
                    state_next = S_CLB_TAKE;
                end
                else if (stat.lvl_last)
                begin
                    state_next = S_CLB_END;
                end
            end
            S_CLB_TAKE:
            begin
                state_next = stat.lvl_last ? S_CLB_END : S_CLB_STEP;
            end
            S_CLB_END:
            begin
                case (phase_reg)
                    PH_MEET:
                    begin
                        state_next = stat.a_eq_b ? S_PATH : S_LCA_RD;
                    end
                    PH_DIST_U:
                    begin
                        phase_next = PH_DIST_V;
                        state_next = S_CLB_STEP;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_LCA_RD:
            begin
                state_next = S_LCA_CMP;
            end
            S_LCA_CMP:
            begin
                state_next = stat.lvl_zero ? S_LCA_TOP : S_LCA_RD;
            end
            S_LCA_TOP:
            begin
                state_next = S_LCA_FIN;
            end
            S_LCA_FIN:
            begin
                state_next = stat.x_ne_y ? S_FIN : S_PATH;
            end
            S_PATH:
            begin
                if (stat.typ == REQ_DIST)
                begin
                    phase_next = PH_DIST_U;
                    state_next = S_CLB_STEP;
                end
                else
                begin
                    phase_next = PH_KTH;
                    state_next = stat.k_bad ? S_FIN : S_CLB_STEP;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath commands and handshake
    always_comb
    begin
        cmd.op         = OP_NOP;
        cmd.st         = ST_OK;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_CLEAR:     cmd.op = OP_CLEAR;
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = OP_CAPTURE;
                end
            end
            S_CHECK:
            begin
                cmd.st = ST_NOT_LOADED;
                if (stat.typ == REQ_LOAD)
                begin
                    if (stat.load_n_bad || (!stat.is_root && stat.load_p_fail))
                    begin
                        cmd.op = OP_STATUS;
                    end
                end
                else if (stat.query_fail)
                begin
                    cmd.op = OP_STATUS;
                end
            end
            S_ROOT_WR:   cmd.op = OP_ROOT_WR;
            S_LOAD_BASE: cmd.op = OP_LOAD_BASE;
            S_LOAD_RD:   cmd.op = OP_LOAD_RD;
            S_LOAD_WR:   cmd.op = OP_LOAD_WR;
            S_MARK:      cmd.op = OP_MARK;
            S_MEET_INIT: cmd.op = OP_MEET_INIT;
            S_CLB_STEP:  cmd.op = OP_CLB_STEP;
            S_CLB_TAKE:  cmd.op = OP_CLB_TAKE;
            S_CLB_END:
            begin
                if (phase_reg == PH_MEET && !stat.a_eq_b)
                begin
                    cmd.op = OP_LCA_INIT;
                end
                else if (phase_reg == PH_DIST_U)
                begin
                    cmd.op = OP_DIST_V;
                end
            end
            S_LCA_RD:    cmd.op = OP_LCA_RD;
            S_LCA_CMP:   cmd.op = OP_LCA_CMP;
            S_LCA_TOP:   cmd.op = OP_LCA_TOP;
            S_LCA_FIN:
            begin
                if (stat.x_ne_y)
                begin
                    cmd.op = OP_STATUS;
                    cmd.st = ST_NO_MEET;
                end
                else
                begin
                    cmd.op = OP_LCA_FIN;
                end
            end
            S_PATH:
            begin
                if (stat.typ == REQ_DIST)
                begin
                    cmd.op = OP_DIST_U;
                end
                else if (stat.k_bad)
                begin
                    cmd.op = OP_STATUS;
                    cmd.st = ST_K_RANGE;
                end
                else
                begin
                    cmd.op = OP_KTH;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.op         = OP_EMIT;
                    rsp_valid_next = 1'b1;
                end
            end
            default:     cmd.op = OP_NOP;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            phase_reg     <= PH_MEET;
            clr_req_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_req_reg   <= clr_req_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // an accepted request is decoded next
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == S_DECODE)
        else $error("accepted request not decoded");
    // a finished request waits while the response slot is full
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && rsp_valid_reg && !rsp_ready |=> state_reg == S_FIN)
        else $error("response overwritten");
    // a new response only comes from the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("response raised outside finish");
endmodule
`default_nettype wire
